// File: hdl/rpa_pkg.sv
// Package for the reference-counted page allocator.
// Holds sizing constants, command and error codes, payload structs and the
// controller-to-datapath command struct. No dependencies.
package rpa_pkg;

  // Sizing.
  localparam int NUM_PAGES   = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int PAGE_W      = 6;
  localparam int PAGE_OUT_W  = PAGE_W + 1;
  localparam int CMD_W       = 3;
  localparam int ERR_W       = 3;

  // Only pages that a 6-bit page number can name get storage.
  localparam int SEARCH_W    = 1 << PAGE_W;
  localparam int STORE_DEPTH = (NUM_PAGES < SEARCH_W) ? NUM_PAGES : SEARCH_W;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  // Free-page search is split into groups of eight pages.
  localparam int GRP_W     = 8;
  localparam int GRP_IDX_W = $clog2(GRP_W);
  localparam int NUM_GRP   = SEARCH_W / GRP_W;
  localparam int GRP_SEL_W = PAGE_W - GRP_IDX_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [PAGE_OUT_W-1:0]  ASSIGN_FLAG = PAGE_OUT_W'(1) << PAGE_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_REF = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLAIM   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_USE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK           = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_FREE      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_ADD_FREE     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_CLAIM_USED   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_RELEASE_FREE = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [PAGE_OUT_W-1:0] page_in;
  } req_t;

  typedef struct packed {
    logic [PAGE_OUT_W-1:0] page_out;
    logic [ERR_W-1:0]      error_code;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic find;     // free-page group search cycle
    logic commit;   // update the count store and the result register
  } ctrl_cmd_t;

endpackage

// File: hdl/rpa_ctrl.sv
// Controller state machine of the reference-counted page allocator.
// Depends on rpa_pkg; drives the datapath through a ctrl_cmd_t struct.
module rpa_ctrl import rpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CMD_W-1:0] command,
  output logic             busy,
  output logic             out_valid,
  output ctrl_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Allocate goes through the search path; all else reads the count first.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (command == CMD_ALLOC) ? S_FIND : S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_FIND: state_nxt = S_PICK;
      S_EXEC: state_nxt = S_IDLE;
      S_PICK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = accept;
    cmd.find    = (state_r == S_FIND);
    cmd.commit  = (state_r == S_EXEC) || (state_r == S_PICK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  assign out_valid = out_valid_r;

  // Every accepted request gets its result strobe, registered from the commit of its execute or pick state.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid_r)
    else $error("result strobe missing three cycles after a request");

  // A result is only presented once the controller is back to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while a request is still in work");

endmodule

// File: hdl/rpa_dpath.sv
// Datapath of the reference-counted page allocator: request register, count
// memory, in-use bitmap, two-level free-page search and result register.
// Depends on rpa_pkg; controlled by rpa_ctrl through ctrl_cmd_t.
module rpa_dpath import rpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      in_req,
  input  ctrl_cmd_t cmd,
  output rsp_t      rsp
);

  req_t                   req_r;
  logic [COUNT_WIDTH-1:0] count_mem [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0] rd_r;
  logic [STORE_DEPTH-1:0] used_r;
  logic [SEARCH_W-1:0]    free_vec;
  logic [NUM_GRP-1:0]     grp_any;
  logic [GRP_IDX_W-1:0]   grp_idx [NUM_GRP];
  logic [NUM_GRP-1:0]     grp_any_r;
  logic [GRP_IDX_W-1:0]   grp_idx_r [NUM_GRP];
  logic                   found;
  logic [PAGE_W-1:0]      alloc_page;
  logic [PAGE_W-1:0]      page;
  logic [IDX_W-1:0]       idx;
  logic                   in_range;
  logic                   in_use;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] bumped;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   used_set;
  logic                   used_clr;
  rsp_t                   rsp_nxt;
  rsp_t                   rsp_r;

  // Request register; the assigned flag bit of the page is dropped where the page number is taken from it.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
  end

  assign page     = req_r.page_in[PAGE_W-1:0];
  assign idx      = page[IDX_W-1:0];
  assign in_range = ({1'b0, page} < (PAGE_W + 1)'(STORE_DEPTH));

  // A page whose in-use bit is clear reads as count zero, so the memory
  // itself needs no clearing after reset.
  assign in_use = used_r[idx];
  assign cur    = in_use ? rd_r : '0;
  assign bumped = (cur == COUNT_MAX) ? COUNT_MAX : cur + COUNT_ONE;

  // Free map padded to the searchable width; pages without storage never
  // show as free.
  for (genvar i = 0; i < SEARCH_W; i++) begin : g_free
    if (i < STORE_DEPTH) begin : g_store
      assign free_vec[i] = !used_r[i];
    end else begin : g_none
      assign free_vec[i] = 1'b0;
    end
  end

  // First search level: lowest free page inside each group of eight.
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any[g] = |free_vec[g*GRP_W +: GRP_W];
      grp_idx[g] = '0;
      for (int j = GRP_W - 1; j >= 0; j--) begin
        if (free_vec[g*GRP_W + j]) begin
          grp_idx[g] = GRP_IDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      grp_any_r <= grp_any;
      grp_idx_r <= grp_idx;
    end
  end

  // Second search level: lowest group that has a free page.
  always_comb begin
    found      = 1'b0;
    alloc_page = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found      = 1'b1;
        alloc_page = {GRP_SEL_W'(g), grp_idx_r[g]};
      end
    end
  end

  // Command execution: count update and result for the current request.
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = idx;
    wr_data  = bumped;
    used_set = 1'b0;
    used_clr = 1'b0;
    rsp_nxt  = '{page_out: '0, error_code: ERR_OK};
    case (req_r.command)
      CMD_ALLOC: begin
        if (found) begin
          wr_en    = 1'b1;
          wr_idx   = alloc_page[IDX_W-1:0];
          wr_data  = COUNT_ONE;
          used_set = 1'b1;
          rsp_nxt.page_out = ASSIGN_FLAG | {1'b0, alloc_page};
        end else begin
          rsp_nxt.error_code = ERR_NO_FREE;
        end
      end
      CMD_ADD_REF: begin
        if (!in_range || !in_use) begin
          rsp_nxt.error_code = ERR_ADD_FREE;
        end else begin
          wr_en = 1'b1;
          rsp_nxt.page_out = {1'b0, page};
        end
      end
      CMD_CLAIM: begin
        if (!in_range || in_use) begin
          rsp_nxt.error_code = ERR_CLAIM_USED;
        end else begin
          wr_en    = 1'b1;
          wr_data  = COUNT_ONE;
          used_set = 1'b1;
          rsp_nxt.page_out = ASSIGN_FLAG | {1'b0, page};
        end
      end
      CMD_USE: begin
        if (!in_range) begin
          rsp_nxt.error_code = ERR_CLAIM_USED;
        end else begin
          wr_en    = 1'b1;
          used_set = 1'b1;
          rsp_nxt.page_out = ASSIGN_FLAG | {1'b0, page};
        end
      end
      CMD_RELEASE: begin
        if (!in_range || !in_use) begin
          rsp_nxt.error_code = ERR_RELEASE_FREE;
        end else begin
          wr_en    = 1'b1;
          wr_data  = cur - COUNT_ONE;
          used_clr = (cur == COUNT_ONE);
        end
      end
      default: begin
        rsp_nxt = '{page_out: '0, error_code: ERR_OK};
      end
    endcase
  end

  // Count memory: one write port, registered read at the request's page.
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      count_mem[wr_idx] <= wr_data;
    end
    rd_r <= count_mem[idx];
  end

  // In-use bitmap; reset marks every page free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.commit) begin
      if (used_set) begin
        used_r[wr_idx] <= 1'b1;
      end else if (used_clr) begin
        used_r[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp = rsp_r;

  // A page handed out, claimed or used is in use right after the commit.
  a_set_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && used_set) |=> used_r[$past(wr_idx)])
    else $error("page not marked in use after it was taken");

  // Releasing the last reference frees the page.
  a_clr_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && used_clr) |=> !used_r[$past(wr_idx)])
    else $error("page still in use after its last release");

  // A failed command never returns a page.
  a_err_page: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (rsp_nxt.error_code != ERR_OK)) |=> (rsp_r.page_out == '0))
    else $error("page number returned with an error");

endmodule

// File: hdl/refcounted_page_allocator.sv
// Top level of the reference-counted page allocator.
// Depends on rpa_pkg, rpa_ctrl and rpa_dpath.
//
//   channel   ports                     handshake
//   request   start, busy, in_req       taken when start is high and busy low
//   result    out_valid, out_rsp        one-cycle strobe, cannot be held off
//
// Each request passes through the read and execute states (find and pick for
// allocate); the result strobe comes as busy drops, so a new request can be taken
// in the cycle of the last result. The states come from the registered read of
// the count memory (read, then update) and, for allocate, from the registered
// two-level free-page search. Synchronous reset frees every page at once
// through the in-use bitmap; no clearing pass is needed.
module refcounted_page_allocator import rpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  ctrl_cmd_t cmd;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .command   (in_req.command),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rpa_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .cmd    (cmd),
    .rsp    (out_rsp)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for refcounted_page_allocator: directed and random request
// streams, each result compared against an in-bench model of the per-page counts.
// Depends on rpa_pkg and the allocator RTL.
module tb_top;
  import rpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 370;
  localparam int MAX_GAP        = 14;
  localparam int COUNT_STEPS    = 12;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  refcounted_page_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  always #10 clk = ~clk;

  // Model of the count table and the queue of results still to arrive.
  logic [COUNT_WIDTH-1:0] page_count [NUM_PAGES];
  rsp_t expected_rsp_q [$];
  int   gap_limit = MAX_GAP;
  int   requests_sent = 0;
  int   results_checked = 0;
  int   mismatches = 0;
  int   err_seen [1 << ERR_W] = '{default: 0};
  int   idle_cycles = 0;

  // Computes the result of one request and applies it to the count table.
  function automatic rsp_t predict_result(input req_t req);
    rsp_t rsp;
    logic [PAGE_W-1:0] pg;
    bit   has_store;
    bit   found;
    int   i;
    rsp.page_out   = '0;
    rsp.error_code = ERR_OK;
    pg        = req.page_in[PAGE_W-1:0];
    has_store = int'(pg) < NUM_PAGES;
    found     = 1'b0;
    case (req.command)
      CMD_ALLOC: begin
        for (i = 0; i < NUM_PAGES && i < SEARCH_W; i++) begin
          if (!found && page_count[i] == '0) begin
            found         = 1'b1;
            page_count[i] = COUNT_ONE;
            rsp.page_out  = PAGE_OUT_W'(i) | ASSIGN_FLAG;
          end
        end
        if (!found) rsp.error_code = ERR_NO_FREE;
      end
      CMD_ADD_REF: begin
        if (!has_store || page_count[pg] == '0) begin
          rsp.error_code = ERR_ADD_FREE;
        end else begin
          if (page_count[pg] != COUNT_MAX) page_count[pg] = page_count[pg] + 1'b1;
          rsp.page_out = PAGE_OUT_W'(pg);
        end
      end
      CMD_CLAIM: begin
        if (!has_store || page_count[pg] != '0) begin
          rsp.error_code = ERR_CLAIM_USED;
        end else begin
          page_count[pg] = COUNT_ONE;
          rsp.page_out   = PAGE_OUT_W'(pg) | ASSIGN_FLAG;
        end
      end
      CMD_USE: begin
        if (!has_store) begin
          rsp.error_code = ERR_CLAIM_USED;
        end else begin
          if (page_count[pg] != COUNT_MAX) page_count[pg] = page_count[pg] + 1'b1;
          rsp.page_out = PAGE_OUT_W'(pg) | ASSIGN_FLAG;
        end
      end
      CMD_RELEASE: begin
        if (!has_store || page_count[pg] == '0) begin
          rsp.error_code = ERR_RELEASE_FREE;
        end else begin
          page_count[pg] = page_count[pg] - 1'b1;
        end
      end
      default: begin
        // Unknown commands are ignored and answer all zero.
      end
    endcase
    return rsp;
  endfunction

  // Picks a page that is in use (or free), starting the scan at a random page.
  function automatic logic [PAGE_W-1:0] pick_page(input bit want_used);
    int base;
    int i;
    int idx;
    bit found;
    logic [PAGE_W-1:0] pg;
    base  = $urandom_range(0, SEARCH_W - 1);
    pg    = PAGE_W'(base);
    found = 1'b0;
    for (i = 0; i < SEARCH_W; i++) begin
      idx = (base + i) % SEARCH_W;
      if (!found && idx < NUM_PAGES && ((page_count[idx] != '0) == want_used)) begin
        found = 1'b1;
        pg    = PAGE_W'(idx);
      end
    end
    return pg;
  endfunction

  // Sends one request after a random gap and records its expected result.
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [PAGE_OUT_W-1:0] page);
    int   gap;
    req_t req;
    gap         = $urandom_range(0, gap_limit);
    req.command = cmd;
    req.page_in = page;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    expected_rsp_q.push_back(predict_result(req));
    requests_sent++;
  endtask

  // Every command once or more, flag bit on and off, error paths and unknown codes.
  task automatic test_basic_commands();
    int c;
    send_req(CMD_ALLOC, 7'h7F);
    send_req(CMD_ALLOC, 7'h00);
    send_req(CMD_ADD_REF, ASSIGN_FLAG);
    send_req(CMD_USE, 7'd5);
    send_req(CMD_USE, ASSIGN_FLAG | 7'd5);
    send_req(CMD_RELEASE, 7'd5);
    send_req(CMD_RELEASE, ASSIGN_FLAG | 7'd5);
    send_req(CMD_RELEASE, 7'd5);
    send_req(CMD_ADD_REF, 7'd5);
    send_req(CMD_CLAIM, 7'h7F);
    send_req(CMD_CLAIM, 7'h3F);
    send_req(CMD_RELEASE, 7'h7F);
    send_req(CMD_CLAIM, 7'h3F);
    send_req(CMD_CLAIM, 7'h00);
    send_req(CMD_ADD_REF, 7'h7E);
    for (c = int'(CMD_RELEASE) + 1; c < (1 << CMD_W); c++) begin
      send_req(CMD_W'(c), 7'h7F);
    end
  endtask

  // Fills the whole table, keeps allocating on a full table, then empties it.
  task automatic test_table_exhaustion();
    int i;
    for (i = 0; i <= SEARCH_W; i++) begin
      send_req(CMD_ALLOC, PAGE_OUT_W'($urandom));
    end
    send_req(CMD_USE, 7'd20);
    send_req(CMD_RELEASE, 7'd40);
    send_req(CMD_RELEASE, ASSIGN_FLAG | 7'd7);
    send_req(CMD_ALLOC, 7'd0);
    send_req(CMD_ALLOC, 7'd0);
    send_req(CMD_ALLOC, 7'd0);
    for (i = 0; i < NUM_PAGES; i++) begin
      while (page_count[i] != '0) send_req(CMD_RELEASE, PAGE_OUT_W'(i));
    end
  endtask

  // Raises one count back to back, releases it down to free, then steps past zero.
  task automatic test_count_up_down();
    logic [PAGE_OUT_W-1:0] pg;
    bit alt;
    int i;
    pg        = 7'd9;
    alt       = 1'b0;
    gap_limit = 0;
    send_req(CMD_USE, pg);
    for (i = 0; i < COUNT_STEPS; i++) begin
      send_req(alt ? CMD_USE : CMD_ADD_REF, pg | (alt ? ASSIGN_FLAG : '0));
      alt = !alt;
    end
    while (page_count[pg[PAGE_W-1:0]] != '0) send_req(CMD_RELEASE, pg);
    send_req(CMD_RELEASE, pg);
    send_req(CMD_ADD_REF, pg);
    gap_limit = MAX_GAP;
  endtask

  // Mostly well-formed traffic aimed at used or free pages, in phases that fill or
  // drain the table; the rest goes to random pages and unknown commands.
  task automatic test_random_mix(input int n_items);
    int k;
    int roll;
    bit fill;
    int t_alloc;
    int t_claim;
    int t_use;
    int t_add;
    bit aimed;
    logic [CMD_W-1:0] cmd;
    logic [PAGE_W-1:0] pg;
    fill    = 1'b1;
    t_alloc = 0;
    t_claim = 0;
    t_use   = 0;
    t_add   = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 50 == 0) begin
        fill      = $urandom_range(0, 1);
        gap_limit = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        t_alloc   = fill ? 40 : 15;
        t_claim   = t_alloc + (fill ? 15 : 10);
        t_use     = t_claim + (fill ? 10 : 5);
        t_add     = t_use + 15;
      end
      roll  = $urandom_range(0, 99);
      aimed = $urandom_range(0, 4) != 0;
      pg    = PAGE_W'($urandom);
      if (roll < t_alloc) begin
        cmd = CMD_ALLOC;
      end else if (roll < t_claim) begin
        cmd = CMD_CLAIM;
        if (aimed) pg = pick_page(1'b0);
      end else if (roll < t_use) begin
        cmd = CMD_USE;
        if (aimed) pg = pick_page(1'b1);
      end else if (roll < t_add) begin
        cmd = CMD_ADD_REF;
        if (aimed) pg = pick_page(1'b1);
      end else if (roll < 95) begin
        cmd = CMD_RELEASE;
        if (aimed) pg = pick_page(1'b1);
      end else begin
        cmd = CMD_W'($urandom_range(int'(CMD_RELEASE) + 1, (1 << CMD_W) - 1));
      end
      send_req(cmd, {1'($urandom), pg});
    end
    gap_limit = MAX_GAP;
  endtask

  // Each result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    rsp_t exp_rsp;
    if (rst_n && out_valid) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual page_out %h error_code %0d",
                 $time, out_rsp.page_out, out_rsp.error_code);
        mismatches++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (out_rsp.page_out !== exp_rsp.page_out) begin
          $display("%0t: page_out mismatch: expected %h actual %h",
                   $time, exp_rsp.page_out, out_rsp.page_out);
          mismatches++;
        end
        if (out_rsp.error_code !== exp_rsp.error_code) begin
          $display("%0t: error_code mismatch: expected %0d actual %0d",
                   $time, exp_rsp.error_code, out_rsp.error_code);
          mismatches++;
        end
        err_seen[exp_rsp.error_code]++;
        results_checked++;
      end
    end
  end

  // Ends the run if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, expected_rsp_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    foreach (page_count[i]) page_count[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_table_exhaustion();
    test_count_up_down();
    test_random_mix(RANDOM_ITEMS);

    // Wait for every outstanding result, then let the pipeline settle.
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: command basics, full table, count up and down, random mix.",
             requests_sent);
    $display("Checked %0d results: ok %0d, no free %0d, add free %0d, claim used %0d, %s %0d.",
             results_checked, err_seen[ERR_OK], err_seen[ERR_NO_FREE],
             err_seen[ERR_ADD_FREE], err_seen[ERR_CLAIM_USED], "release free",
             err_seen[ERR_RELEASE_FREE]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: refcounted_page_allocator.f
hdl/rpa_pkg.sv
hdl/rpa_ctrl.sv
hdl/rpa_dpath.sv
hdl/refcounted_page_allocator.sv
tb/tb_top.sv
